// ===== rtl/hkt_pkg.sv =====
// Shared types and codes for the held key tracker.
// No dependencies; imported by the top level and by the checker.
package hkt_pkg;

  localparam int KEY_W    = 8;
  localparam int CHAR_W   = 21;
  localparam int STATUS_W = 3;
  localparam int MODE_W   = 2;

  localparam logic [MODE_W-1:0] MODE_PRESS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_STORED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HELD    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FLUSHED = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd6;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key_id;
    logic [CHAR_W-1:0] char_code;
  } in_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key_id_out;
    logic [CHAR_W-1:0]   char_code_out;
    logic                last;
  } out_rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CHAR_W-1:0] chr;
  } held_entry_t;

  localparam int ENTRY_W = $bits(held_entry_t);

endpackage

// ===== rtl/hkt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hkt_ram #(
  parameter int WIDTH = 29,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/held_key_tracker_top.sv =====
// Held key tracker: packed set of held keys kept in a RAM, searched one slot per cycle.
// A press or release of a nonzero key to a non-empty set searches at most the held count of
// slots in S_SEARCH; a release that hits passes S_MOVE, writing the tail entry into the freed slot.
// Each result then goes through S_EMIT. A new request is taken only in S_IDLE; a flush emits
// one entry per cycle while the output register is free; a mode-three request stays in S_IDLE.
// Reset: synchronous; clears count and control state, RAM left undefined. Uses hkt_pkg, hkt_ram.
module held_key_tracker_top #(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hkt_pkg::in_req_t in_req,
  output logic             out_valid,
  input  logic             out_ready,
  output hkt_pkg::out_rsp_t out_rsp
);

  import hkt_pkg::*;

  localparam int IW = $clog2(CAPACITY);      // slot index width
  localparam int CW = $clog2(CAPACITY + 1);  // count width, holds CAPACITY itself

  // One-hot sequencer
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,  // take a request
    S_SEARCH = 5'b00010,  // compare one slot per cycle
    S_MOVE   = 5'b00100,  // tail entry read back, write it into the freed slot
    S_FLUSH  = 5'b01000,  // stream entries out in slot order
    S_EMIT   = 5'b10000   // hand the single result to the output register
  } state_t;

  state_t              state_r, state_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [IW-1:0]       slot_r, slot_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [CHAR_W-1:0]   char_r, char_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_rsp_t            out_rsp_r, out_rsp_nxt;

  // RAM port signals
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  held_entry_t   wr_entry;
  logic [IW-1:0] rd_addr;
  held_entry_t   rd_entry;

  logic          accept;
  logic          slot_free;
  logic [IW-1:0] tail;
  logic          at_tail;
  logic          full;
  logic          hit;

  hkt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // The output register frees up when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_ready;
  // Last occupied slot; only used while the count is nonzero
  assign tail      = IW'(count_r - CW'(1));
  assign at_tail   = (idx_r == tail);
  assign full      = (count_r == CW'(CAPACITY));
  assign hit       = (rd_entry.key == key_r);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    count_nxt     = count_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    char_nxt      = char_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_rsp_nxt   = out_rsp_r;
    wr_en         = 1'b0;
    wr_addr       = IW'(count_r);
    wr_entry      = '{key: key_r, chr: char_r};
    rd_addr       = '0;

    // Drain the output register when the consumer takes it
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          mode_nxt = in_req.mode;
          key_nxt  = in_req.key_id;
          char_nxt = in_req.char_code;
          priority if (in_req.mode == MODE_NONE) begin
            // drop: no result, set unchanged
          end else if (in_req.mode == MODE_FLUSH) begin
            if (count_r == '0) begin
              key_nxt    = '0;
              status_nxt = ST_EMPTY;
              state_nxt  = S_EMIT;
            end else begin
              state_nxt = S_FLUSH;
            end
          end else if (in_req.key_id == '0) begin
            // key zero is never stored nor found
            status_nxt = (in_req.mode == MODE_PRESS) ? ST_STORED : ST_MISSING;
            state_nxt  = S_EMIT;
          end else if (count_r == '0) begin
            if (in_req.mode == MODE_PRESS) begin
              wr_en      = 1'b1;
              wr_addr    = '0;
              wr_entry   = '{key: in_req.key_id, chr: in_req.char_code};
              count_nxt  = CW'(1);
              status_nxt = ST_STORED;
            end else begin
              status_nxt = ST_MISSING;
            end
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
        rd_addr = idx_nxt;
      end

      S_SEARCH: begin
        priority if (hit) begin
          if (mode_r == MODE_PRESS) begin
            status_nxt = ST_HELD;
            state_nxt  = S_EMIT;
          end else begin
            // fetch the tail entry to fill the freed slot
            slot_nxt  = idx_r;
            state_nxt = S_MOVE;
          end
          rd_addr = tail;
        end else if (at_tail) begin
          if (mode_r == MODE_PRESS) begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              wr_en      = 1'b1;
              count_nxt  = count_r + CW'(1);
              status_nxt = ST_STORED;
            end
          end else begin
            status_nxt = ST_MISSING;
          end
          state_nxt = S_EMIT;
          rd_addr   = idx_r;
        end else begin
          idx_nxt = IW'(idx_r + 1'b1);
          rd_addr = idx_nxt;
        end
      end

      S_MOVE: begin
        wr_en      = 1'b1;
        wr_addr    = slot_r;
        wr_entry   = rd_entry;
        count_nxt  = count_r - CW'(1);
        status_nxt = ST_REMOVED;
        state_nxt  = S_EMIT;
      end

      S_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '{status: ST_FLUSHED, key_id_out: rd_entry.key,
                            char_code_out: rd_entry.chr, last: at_tail};
          if (at_tail) begin
            count_nxt = '0;
            idx_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = IW'(idx_r + 1'b1);
          end
        end
        // hold the address while stalled so the read data stays put
        rd_addr = idx_nxt;
      end

      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '{status: status_r, key_id_out: key_r,
                            char_code_out: '0, last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    slot_r    <= slot_nxt;
    mode_r    <= mode_nxt;
    key_r     <= key_nxt;
    char_r    <= char_nxt;
    status_r  <= status_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

endmodule

// ===== rtl/hkt_checker.sv =====
// Port-level checks for the held key tracker, bound onto the top level.
// Depends on hkt_pkg and held_key_tracker_top.
module hkt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input hkt_pkg::in_req_t  in_req,
  input logic              out_valid,
  input logic              out_ready,
  input hkt_pkg::out_rsp_t out_rsp
);

  import hkt_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("result changed while stalled");

  // Any real request keeps the block busy on the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req.mode != MODE_NONE) |=> !in_ready)
    else $error("ready while a request is in progress");

  // Only flushed entries may be non-final or carry a character code
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status != ST_FLUSHED)
      |-> out_rsp.last && (out_rsp.char_code_out == '0))
    else $error("single result malformed");

  // A flush of an empty set reports no key
  a_empty_flush: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status == ST_EMPTY) |-> (out_rsp.key_id_out == '0))
    else $error("empty flush carries a key");

endmodule

bind held_key_tracker_top hkt_checker u_hkt_checker (.*);

// ===== test/held_key_tracker_top_tb.sv =====
// Self-checking bench for held_key_tracker_top: random and directed press,
// release and flush requests are checked against a behavioural tracker model.
// Depends on hkt_pkg and the RTL of held_key_tracker_top.
`timescale 1ns / 100ps

module held_key_tracker_top_tb;
  import hkt_pkg::*;

  localparam int CAPACITY = 64;
  localparam int ITEMS = 420;
  localparam int IDLE_PCT = 36;
  localparam int STALL_LIMIT = 4000;
  localparam logic [CHAR_W-1:0] CHAR_MAX = 21'd1114111;

  // One planned request; drain holds it back until every result is in
  typedef struct packed {
    logic    drain;
    in_req_t req;
  } queued_req_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_req_t   in_req = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_rsp_t  out_rsp;

  queued_req_t pending_reqs[$];
  out_rsp_t    rsp_expected[$];

  // Behavioural copy of the held set
  logic [KEY_W-1:0]  model_key [CAPACITY];
  logic [CHAR_W-1:0] model_chr [CAPACITY];
  int                model_cnt = 0;

  int  planned_items = 0;
  int  total_reqs = 0;
  int  accepted_reqs = 0;
  int  sent = 0;
  int  errors = 0;
  int  stall_cycles = 0;
  int  results_seen = 0;
  int  full_refusals = 0;
  int  removals = 0;
  int  flush_run = 0;
  int  longest_flush = 0;
  bit  req_accepted = 1'b0;

  held_key_tracker_top #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp  (out_rsp)
  );

  always #6 clk = ~clk;

  // Slot of a held key, or -1 when the key is not in the set
  function automatic int find_held(input logic [KEY_W-1:0] key);
    int i;
    for (i = 0; i < model_cnt; i++) begin
      if (model_key[i] == key) return i;
    end
    return -1;
  endfunction

  // Advance the model by one accepted request and queue the results it owes
  task automatic track_event(input in_req_t r);
    out_rsp_t rsp;
    int       slot;
    int       i;
    rsp = '0;
    rsp.last = 1'b1;
    rsp.key_id_out = r.key_id;
    case (r.mode)
      MODE_PRESS: begin
        if (r.key_id == '0) begin
          rsp.status = ST_STORED;
        end else if (find_held(r.key_id) >= 0) begin
          rsp.status = ST_HELD;
        end else if (model_cnt >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          model_key[model_cnt] = r.key_id;
          model_chr[model_cnt] = r.char_code;
          model_cnt++;
          rsp.status = ST_STORED;
        end
        rsp_expected.push_back(rsp);
      end
      MODE_RELEASE: begin
        slot = (r.key_id == '0) ? -1 : find_held(r.key_id);
        if (slot < 0) begin
          rsp.status = ST_MISSING;
        end else begin
          // fill the hole with the tail entry to keep the set packed
          model_key[slot] = model_key[model_cnt-1];
          model_chr[slot] = model_chr[model_cnt-1];
          model_cnt--;
          rsp.status = ST_REMOVED;
        end
        rsp_expected.push_back(rsp);
      end
      MODE_FLUSH: begin
        if (model_cnt == 0) begin
          rsp.status = ST_EMPTY;
          rsp.key_id_out = '0;
          rsp_expected.push_back(rsp);
        end else begin
          for (i = 0; i < model_cnt; i++) begin
            rsp.status = ST_FLUSHED;
            rsp.key_id_out = model_key[i];
            rsp.char_code_out = model_chr[i];
            rsp.last = (i == model_cnt - 1);
            rsp_expected.push_back(rsp);
          end
          model_cnt = 0;
        end
      end
      default: ; // drop: the block ignores this mode
    endcase
  endtask

  function automatic logic [CHAR_W-1:0] any_char();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CHAR_MAX;
      default: return CHAR_W'($urandom_range(0, CHAR_MAX));
    endcase
  endfunction

  task automatic plan_req(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                          input logic [CHAR_W-1:0] chr, input logic drain);
    queued_req_t q;
    q.drain = drain;
    q.req.mode = mode;
    q.req.key_id = key;
    q.req.char_code = chr;
    pending_reqs.push_back(q);
    planned_items++;
  endtask

  // Short run of presses and releases over a small key pool, so that hits,
  // misses and repeats are all common; noise requests mixed in
  task automatic plan_mix();
    logic [KEY_W-1:0] pool [12];
    int n_keys;
    int len;
    int pick;
    int i;
    n_keys = $urandom_range(2, 12);
    len = $urandom_range(10, 30);
    for (i = 0; i < n_keys; i++) pool[i] = KEY_W'($urandom_range(1, 255));
    for (i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        plan_req(MODE_PRESS, pool[$urandom_range(0, n_keys - 1)], any_char(), 1'b0);
      else if (pick < 80)
        plan_req(MODE_RELEASE, pool[$urandom_range(0, n_keys - 1)], any_char(), 1'b0);
      else if (pick < 85)
        plan_req(MODE_FLUSH, KEY_W'($urandom), any_char(), 1'b0);
      else if (pick < 92)
        plan_req(MODE_NONE, KEY_W'($urandom), any_char(), 1'b0);
      else
        plan_req(MODE_W'($urandom_range(0, 1)), '0, any_char(), 1'b0);
    end
    if ($urandom_range(0, 1) == 1) plan_req(MODE_FLUSH, '0, any_char(), 1'b0);
  endtask

  // Fill the set to capacity with distinct keys, push past full, punch holes
  // at the ends and middle, refill, then flush every slot
  task automatic plan_fill();
    logic [KEY_W-1:0] perm [255];
    logic [KEY_W-1:0] tmp;
    int i;
    int j;
    for (i = 0; i < 255; i++) perm[i] = KEY_W'(i + 1);
    for (i = 254; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    // hold the sender until the bench has caught up, then start from empty
    plan_req(MODE_FLUSH, '0, '0, 1'b1);
    for (i = 0; i < CAPACITY; i++) plan_req(MODE_PRESS, perm[i], any_char(), 1'b0);
    plan_req(MODE_PRESS, perm[CAPACITY], any_char(), 1'b0);
    plan_req(MODE_PRESS, perm[$urandom_range(0, CAPACITY - 1)], any_char(), 1'b0);
    plan_req(MODE_PRESS, '0, any_char(), 1'b0);
    plan_req(MODE_RELEASE, perm[CAPACITY-1], any_char(), 1'b0);
    plan_req(MODE_RELEASE, perm[0], any_char(), 1'b0);
    plan_req(MODE_RELEASE, perm[$urandom_range(1, CAPACITY - 2)], any_char(), 1'b0);
    plan_req(MODE_RELEASE, perm[CAPACITY+2], any_char(), 1'b0);
    plan_req(MODE_PRESS, perm[CAPACITY+1], any_char(), 1'b0);
    plan_req(MODE_PRESS, perm[CAPACITY], any_char(), 1'b0);
    plan_req(MODE_PRESS, perm[CAPACITY+2], any_char(), 1'b0);
    plan_req(MODE_PRESS, perm[CAPACITY+3], any_char(), 1'b0);
    plan_req(MODE_FLUSH, KEY_W'($urandom), any_char(), 1'b0);
  endtask

  // Driver: present requests at the falling edge, hold each until accepted
  always @(negedge clk) begin : driver
    queued_req_t nxt;
    logic        steady;
    if (rst_n) begin
      // a stretch in the middle of the run with neither side idling
      steady = (sent >= 180 && sent < 260);
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      if (!in_valid || req_accepted) begin
        req_accepted = 1'b0;
        if (pending_reqs.size() == 0 ||
            (pending_reqs[0].drain && rsp_expected.size() != 0) ||
            (!steady && $urandom_range(0, 99) < IDLE_PCT)) begin
          in_valid <= 1'b0;
        end else begin
          nxt = pending_reqs.pop_front();
          in_req <= nxt.req;
          in_valid <= 1'b1;
          sent++;
        end
      end
    end
  end

  // Monitor: sample both channels at the rising edge, check results in order
  always @(posedge clk) begin : monitor
    out_rsp_t want;
    logic     fired;
    if (rst_n) begin
      fired = 1'b0;
      // check before predicting, so a stray result cannot claim a new request
      if (out_valid && out_ready) begin
        fired = 1'b1;
        results_seen++;
        if (rsp_expected.size() == 0) begin
          $error("unexpected result: status %0d key %0d char %0d last %0d",
                 out_rsp.status, out_rsp.key_id_out, out_rsp.char_code_out,
                 out_rsp.last);
          errors++;
        end else begin
          want = rsp_expected.pop_front();
          if (out_rsp.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_rsp.status);
            errors++;
          end
          if (out_rsp.key_id_out !== want.key_id_out) begin
            $error("key_id_out mismatch: expected %0d, got %0d",
                   want.key_id_out, out_rsp.key_id_out);
            errors++;
          end
          if (out_rsp.char_code_out !== want.char_code_out) begin
            $error("char_code_out mismatch: expected %0d, got %0d",
                   want.char_code_out, out_rsp.char_code_out);
            errors++;
          end
          if (out_rsp.last !== want.last) begin
            $error("last mismatch: expected %0d, got %0d", want.last, out_rsp.last);
            errors++;
          end
        end
        if (out_rsp.status == ST_FULL) full_refusals++;
        if (out_rsp.status == ST_REMOVED) removals++;
        if (out_rsp.status == ST_FLUSHED) begin
          flush_run++;
          if (out_rsp.last && flush_run > longest_flush) longest_flush = flush_run;
          if (out_rsp.last) flush_run = 0;
        end
      end
      if (in_valid && in_ready) begin
        fired = 1'b1;
        track_event(in_req);
        req_accepted = 1'b1;
        accepted_reqs++;
      end
      // watchdog: give up after a long spell with no request or result moving
      if (fired) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  initial begin
    // Directed opening: empty-set cases, key zero, extreme codes, repeats,
    // a mid-slot release, the ignored mode, and a flush of several entries
    plan_req(MODE_FLUSH, 8'hFF, CHAR_MAX, 1'b0);
    plan_req(MODE_RELEASE, 8'h00, '0, 1'b0);
    plan_req(MODE_RELEASE, 8'h55, '0, 1'b0);
    plan_req(MODE_PRESS, 8'h00, CHAR_MAX, 1'b0);
    plan_req(MODE_PRESS, 8'hFF, CHAR_MAX, 1'b0);
    plan_req(MODE_PRESS, 8'h01, '0, 1'b0);
    plan_req(MODE_PRESS, 8'hAA, 21'h0AAAAA, 1'b0);
    plan_req(MODE_PRESS, 8'hFF, 21'd7, 1'b0);
    plan_req(MODE_PRESS, 8'h55, 21'h055555, 1'b0);
    plan_req(MODE_RELEASE, 8'h01, CHAR_MAX, 1'b0);
    plan_req(MODE_RELEASE, 8'h01, '0, 1'b0);
    plan_req(MODE_NONE, 8'h55, CHAR_MAX, 1'b0);
    plan_req(MODE_RELEASE, 8'h55, '0, 1'b0);
    plan_req(MODE_PRESS, 8'h80, 21'h100000, 1'b0);
    plan_req(MODE_PRESS, 8'h7F, 21'h0F0F0F, 1'b0);
    plan_req(MODE_FLUSH, 8'h00, '0, 1'b1);
    plan_req(MODE_FLUSH, 8'h80, 21'h1FFFFF & CHAR_MAX, 1'b0);
    plan_req(MODE_NONE, 8'hFF, CHAR_MAX, 1'b0);
    plan_req(MODE_PRESS, 8'h7F, '0, 1'b0);
    plan_req(MODE_RELEASE, 8'h7F, '0, 1'b0);
    plan_req(MODE_RELEASE, 8'h7F, '0, 1'b0);

    // Random body: mostly pooled press/release runs, two full-table episodes
    while (planned_items < ITEMS) begin
      if (planned_items >= 80 + 150 * (planned_items >= 230) &&
          ((planned_items < 230 && total_reqs == 0) || (planned_items >= 230 && total_reqs == 1))) begin
        plan_fill();
        total_reqs++;
      end else begin
        plan_mix();
      end
    end
    total_reqs = pending_reqs.size();

    // hold reset, then release it away from the sampling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for every request to go in and every result to come out
    while (accepted_reqs < total_reqs || rsp_expected.size() != 0) @(negedge clk);
    repeat (CAPACITY + 8) @(negedge clk);

    $display("Run covered %0d requests and %0d results: %0d removals, %0d full refusals,",
             accepted_reqs, results_seen, removals, full_refusals);
    $display("longest flush %0d entries, %0d mismatches", longest_flush, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
